/* hw/rtl/tlrt_pkg.sv */
`timescale 1ns / 1ps
package tlrt_pkg;

  localparam int SLOT_COUNT_DEF   = 64;
  localparam int TILE_COUNT_DEF   = 1024;
  localparam int VERSION_BITS_DEF = 16;

  localparam int COORD_W  = 10;
  localparam int STRIDE_W = 11;
  localparam int IDX_W    = COORD_W + STRIDE_W;
  localparam int STATUS_W = 3;
  localparam int SLOTOUT_W = 6;

  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 11'd32;
  localparam logic REG_IDX_ROW_STRIDE = 1'b0;

  typedef enum logic [1:0] {
    MODE_ACCESS = 2'd0,
    MODE_MARK   = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_TRANSFER  = 3'd0,
    STS_RESIDENT  = 3'd1,
    STS_MARKED    = 3'd2,
    STS_UNKNOWN   = 3'd3,
    STS_NO_WRITER = 3'd4,
    STS_WRITER    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_IDX,
    S_RD,
    S_MATCH,
    S_SEL,
    S_WRMAP
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] tile_col;
    logic [COORD_W-1:0] tile_row;
    logic [1:0]         access_kind;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOTOUT_W-1:0] slot_index;
  } out_t;

  typedef struct packed {
    logic capture;
    logic upd;
  } cell_ctl_t;

endpackage

/* hw/rtl/tile_lru_residency_tracker.sv */
`timescale 1ns / 1ps
// Results: out-of-range or reserved items finish in the index state (S_IDX); mark-usage
// items and queries of tiles without a slot in the table read (S_RD); slot queries, hits and
// misses into a free slot in the select state (S_SEL); misses that unmap a former tile in
// S_WRMAP. Throughput: one transaction at a time; the receiver cannot stall.
// Reset: after rst_ni rises the tile tables are swept clear with busy high; configuration
// writes are taken throughout.
module tile_lru_residency_tracker #(
  parameter int SLOT_COUNT   = tlrt_pkg::SLOT_COUNT_DEF,
  parameter int TILE_COUNT   = tlrt_pkg::TILE_COUNT_DEF,
  parameter int VERSION_BITS = tlrt_pkg::VERSION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tlrt_pkg::in_t     in_i,
  output logic              busy_o,
  output logic              done_o,
  output tlrt_pkg::out_t    out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int TW = $clog2(TILE_COUNT);
  localparam int VW = VERSION_BITS;
  localparam int CW = SW + 1 + TW + 2 + VW;
  localparam int IW = tlrt_pkg::IDX_W;

  // Configuration register.
  logic [tlrt_pkg::STRIDE_W-1:0] stride_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= tlrt_pkg::ROW_STRIDE_RST;
    end else if (psel && penable && pwrite && paddr[2] == tlrt_pkg::REG_IDX_ROW_STRIDE) begin
      stride_q <= pwdata[tlrt_pkg::STRIDE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tlrt_pkg::REG_IDX_ROW_STRIDE) begin
      prdata = {{(32-tlrt_pkg::STRIDE_W){1'b0}}, stride_q};
    end
  end

  // Tile tables.
  logic          meta_we, map_we;
  logic [TW-1:0] meta_waddr, map_waddr;
  logic [VW:0]   meta_wdata, meta_rdata;
  logic [SW:0]   map_wdata, map_rdata;
  logic [TW-1:0] tile;

  tlrt_ram #(.WIDTH(VW + 1), .DEPTH(TILE_COUNT)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(tile),
    .rdata_o(meta_rdata)
  );

  tlrt_ram #(.WIDTH(SW + 1), .DEPTH(TILE_COUNT)) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(tile),
    .rdata_o(map_rdata)
  );

  // LRU row: position 0 is the oldest slot.
  tlrt_pkg::cell_ctl_t ctl;
  logic [SW-1:0]       target_q, target_d;
  logic [CW-1:0]       cdata [SLOT_COUNT];
  logic [CW-1:0]       new_data;
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT:0]   ge;

  assign ge[0] = 1'b0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic [CW-1:0] nxt;
    if (i == SLOT_COUNT - 1) begin : g_last
      assign nxt = new_data;
    end else begin : g_mid
      assign nxt = cdata[i+1];
    end
    tlrt_cell #(.CW(CW), .SW(SW), .POS(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .target_i(target_q),
      .ge_i    (ge[i]),
      .nxt_i   (nxt),
      .data_o  (cdata[i]),
      .match_o (match[i]),
      .ge_o    (ge[i+1])
    );
  end

  logic [CW-1:0] sel;
  always_comb begin
    sel = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sel = sel | ({CW{match[i]}} & cdata[i]);
    end
  end

  logic [SW-1:0] s_slot;
  logic          s_ov;
  logic [TW-1:0] s_own;
  logic [1:0]    s_mask;
  logic [VW-1:0] s_ver;

  assign s_ver  = sel[VW-1:0];
  assign s_mask = sel[VW+1:VW];
  assign s_own  = sel[VW+2+TW-1:VW+2];
  assign s_ov   = sel[VW+2+TW];
  assign s_slot = sel[CW-1 -: SW];

  // Sequencer.
  tlrt_pkg::state_e state_q, state_d;
  tlrt_pkg::in_t    in_q, in_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [TW-1:0]    clr_q, clr_d;
  logic             done_q, done_d;
  tlrt_pkg::out_t   out_q, out_d;

  assign tile = idx_q[TW-1:0];

  logic          known;
  logic [VW-1:0] tver;
  logic          keep;
  logic [1:0]    nmask;

  assign known = meta_rdata[VW];
  assign tver  = meta_rdata[VW-1:0];
  assign keep  = s_ov && (s_own == tile);

  function automatic logic [tlrt_pkg::SLOTOUT_W-1:0] SLOTOUT_CAST(input logic [SW-1:0] s);
    SLOTOUT_CAST = tlrt_pkg::SLOTOUT_W'(s);
  endfunction

  always_comb begin
    state_d    = state_q;
    in_d       = in_q;
    idx_d      = idx_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    out_d      = out_q;
    target_d   = target_q;
    ctl        = '0;
    new_data   = sel;
    nmask      = s_mask | in_q.access_kind;
    meta_we    = 1'b0;
    meta_waddr = tile;
    meta_wdata = {1'b1, tver};
    map_we     = 1'b0;
    map_waddr  = tile;
    map_wdata  = {1'b1, target_q};
    case (state_q)
      tlrt_pkg::S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        map_we     = 1'b1;
        map_waddr  = clr_q;
        map_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == TW'(TILE_COUNT - 1)) begin
          state_d = tlrt_pkg::S_IDLE;
        end
      end
      tlrt_pkg::S_IDLE: begin
        if (start_i) begin
          in_d    = in_i;
          idx_d   = IW'(in_i.tile_col) * IW'(stride_q) + IW'(in_i.tile_row);
          state_d = tlrt_pkg::S_IDX;
        end
      end
      tlrt_pkg::S_IDX: begin
        if (idx_q >= IW'(TILE_COUNT) || in_q.mode == tlrt_pkg::MODE_RSVD) begin
          out_d   = {tlrt_pkg::STS_UNKNOWN, 6'd0};
          done_d  = 1'b1;
          state_d = tlrt_pkg::S_IDLE;
        end else begin
          state_d = tlrt_pkg::S_RD;
        end
      end
      tlrt_pkg::S_RD: begin
        case (in_q.mode)
          tlrt_pkg::MODE_ACCESS: begin
            target_d = map_rdata[SW] ? map_rdata[SW-1:0] : cdata[0][CW-1 -: SW];
            state_d  = tlrt_pkg::S_MATCH;
          end
          tlrt_pkg::MODE_MARK: begin
            out_d   = {tlrt_pkg::STS_UNKNOWN, 6'd0};
            if (known) begin
              out_d = {tlrt_pkg::STS_MARKED, 6'd0};
              if (in_q.access_kind[1]) begin
                meta_we    = 1'b1;
                meta_wdata = {1'b1, tver + 1'b1};
              end
            end
            done_d  = 1'b1;
            state_d = tlrt_pkg::S_IDLE;
          end
          tlrt_pkg::MODE_QUERY: begin
            if (!known) begin
              out_d   = {tlrt_pkg::STS_UNKNOWN, 6'd0};
              done_d  = 1'b1;
              state_d = tlrt_pkg::S_IDLE;
            end else if (!map_rdata[SW]) begin
              out_d   = {tlrt_pkg::STS_NO_WRITER, 6'd0};
              done_d  = 1'b1;
              state_d = tlrt_pkg::S_IDLE;
            end else begin
              target_d = map_rdata[SW-1:0];
              state_d  = tlrt_pkg::S_MATCH;
            end
          end
          default: begin
            out_d   = {tlrt_pkg::STS_UNKNOWN, 6'd0};
            done_d  = 1'b1;
            state_d = tlrt_pkg::S_IDLE;
          end
        endcase
      end
      tlrt_pkg::S_MATCH: begin
        ctl.capture = 1'b1;
        state_d     = tlrt_pkg::S_SEL;
      end
      tlrt_pkg::S_SEL: begin
        if (in_q.mode == tlrt_pkg::MODE_QUERY) begin
          if (s_mask[1]) begin
            out_d = {tlrt_pkg::STS_WRITER, SLOTOUT_CAST(s_slot)};
          end else begin
            out_d = {tlrt_pkg::STS_NO_WRITER, 6'd0};
          end
          done_d  = 1'b1;
          state_d = tlrt_pkg::S_IDLE;
        end else begin
          ctl.upd = 1'b1;
          if (map_rdata[SW]) begin
            // Hit: the owner stays, the slot version follows the tile version.
            new_data = {s_slot, s_ov, s_own, nmask, tver};
            out_d    = {(s_ver == tver) ? tlrt_pkg::STS_RESIDENT : tlrt_pkg::STS_TRANSFER,
                        SLOTOUT_CAST(s_slot)};
            done_d   = 1'b1;
            state_d  = tlrt_pkg::S_IDLE;
          end else begin
            if (!keep) begin
              nmask = in_q.access_kind;
            end
            new_data = {s_slot, 1'b1, tile, nmask, tver};
            out_d    = {tlrt_pkg::STS_TRANSFER, SLOTOUT_CAST(s_slot)};
            meta_we  = 1'b1;
            if (s_ov && !keep) begin
              // Unmap the evicted tile now and map the new one in the next cycle.
              map_we    = 1'b1;
              map_waddr = s_own;
              map_wdata = '0;
              state_d   = tlrt_pkg::S_WRMAP;
            end else begin
              map_we  = 1'b1;
              done_d  = 1'b1;
              state_d = tlrt_pkg::S_IDLE;
            end
          end
        end
      end
      tlrt_pkg::S_WRMAP: begin
        map_we  = 1'b1;
        done_d  = 1'b1;
        state_d = tlrt_pkg::S_IDLE;
      end
      default: begin
        state_d = tlrt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlrt_pkg::S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    idx_q    <= idx_d;
    out_q    <= out_d;
    target_q <= target_d;
  end

  assign busy_o = (state_q != tlrt_pkg::S_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction did not raise busy");
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlrt_pkg::S_SEL) |-> $onehot(match)) else $error("slot not found once in LRU row");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.status <= 3'd5)) else $error("status code out of range");
`endif

endmodule

/* hw/rtl/tlrt_ram.sv */
`timescale 1ns / 1ps
module tlrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tlrt_cell.sv */
`timescale 1ns / 1ps
module tlrt_cell #(
  parameter int CW  = 8,
  parameter int SW  = 2,
  parameter int POS = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlrt_pkg::cell_ctl_t ctl_i,
  input  logic [SW-1:0]       target_i,
  input  logic                ge_i,
  input  logic [CW-1:0]       nxt_i,
  output logic [CW-1:0]       data_o,
  output logic                match_o,
  output logic                ge_o
);

  localparam logic [SW-1:0] PID = SW'(POS);

  logic [CW-1:0] data_q, data_d;
  logic          match_q, match_d;

  // The cell takes its upper neighbor's entry when it sits at or above the hit position.
  assign ge_o = ge_i | match_q;

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    if (ctl_i.capture) begin
      match_d = (data_q[CW-1 -: SW] == target_i);
    end
    if (ctl_i.upd && ge_o) begin
      data_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q  <= {PID, {(CW-SW){1'b0}}};
      match_q <= 1'b0;
    end else begin
      data_q  <= data_d;
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

/* test/tile_lru_residency_tracker_test.sv */
`timescale 1ns / 1ps
module tile_lru_residency_tracker_test;

  localparam int NSLOT = 64;
  localparam int NTILE = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  tlrt_pkg::in_t in_i = '0;
  logic busy_o, done_o;
  tlrt_pkg::out_t out_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tile_lru_residency_tracker u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy_o(busy_o), .done_o(done_o), .out_o(out_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the tracker state.
  logic [10:0] stride;
  bit          known_q [NTILE];
  logic [15:0] tver_q [NTILE];
  bit          tmap_vld_q [NTILE];
  logic [5:0]  tmap_q [NTILE];
  bit          sown_vld_q [NSLOT];
  logic [9:0]  sown_q [NSLOT];
  logic [1:0]  smask_q [NSLOT];
  logic [15:0] sver_q [NSLOT];
  logic [5:0]  lru_q [NSLOT];

  tlrt_pkg::out_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;

  task automatic clear_shadow();
    for (int i = 0; i < NTILE; i++) begin
      known_q[i] = 0; tver_q[i] = '0; tmap_vld_q[i] = 0; tmap_q[i] = '0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      sown_vld_q[i] = 0; sown_q[i] = '0; smask_q[i] = '0; sver_q[i] = '0;
      lru_q[i] = i[5:0];
    end
    stride = tlrt_pkg::ROW_STRIDE_RST;
  endtask

  function automatic void promote_slot(input logic [5:0] s);
    int p;
    p = 0;
    while (lru_q[p] != s) p++;
    for (int i = p; i < NSLOT - 1; i++) lru_q[i] = lru_q[i + 1];
    lru_q[NSLOT - 1] = s;
  endfunction

  function automatic tlrt_pkg::out_t residency_outcome(input tlrt_pkg::in_t it);
    tlrt_pkg::out_t r;
    int idx;
    logic [5:0] s;
    r.status = tlrt_pkg::STS_UNKNOWN;
    r.slot_index = '0;
    idx = int'(it.tile_col) * int'(stride) + int'(it.tile_row);
    if (idx >= NTILE || tlrt_pkg::mode_e'(it.mode) == tlrt_pkg::MODE_RSVD) return r;
    if (tlrt_pkg::mode_e'(it.mode) == tlrt_pkg::MODE_ACCESS) begin
      known_q[idx] = 1;
      if (!tmap_vld_q[idx]) begin
        s = lru_q[0];
        if (!(sown_vld_q[s] && sown_q[s] == idx[9:0])) begin
          if (sown_vld_q[s]) tmap_vld_q[sown_q[s]] = 0;
          smask_q[s] = '0;
        end
        smask_q[s] |= it.access_kind;
        sown_vld_q[s] = 1; sown_q[s] = idx[9:0];
        tmap_vld_q[idx] = 1; tmap_q[idx] = s;
        promote_slot(s);
        r.status = tlrt_pkg::STS_TRANSFER;
      end else begin
        s = tmap_q[idx];
        promote_slot(s);
        smask_q[s] |= it.access_kind;
        r.status = (sver_q[s] == tver_q[idx]) ? tlrt_pkg::STS_RESIDENT
                                              : tlrt_pkg::STS_TRANSFER;
      end
      sver_q[s] = tver_q[idx];
      r.slot_index = s;
    end else if (!known_q[idx]) begin
      r.status = tlrt_pkg::STS_UNKNOWN;
    end else if (tlrt_pkg::mode_e'(it.mode) == tlrt_pkg::MODE_MARK) begin
      if (it.access_kind[1]) tver_q[idx] = tver_q[idx] + 16'd1;
      r.status = tlrt_pkg::STS_MARKED;
    end else begin
      r.status = tlrt_pkg::STS_NO_WRITER;
      if (tmap_vld_q[idx] && smask_q[tmap_q[idx]][1]) begin
        r.status = tlrt_pkg::STS_WRITER;
        r.slot_index = tmap_q[idx];
      end
    end
    return r;
  endfunction

  // Result checker; done is sampled at the edge that ends its cycle.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_o);
      end else begin
        tlrt_pkg::out_t e;
        e = expected_q.pop_front();
        if (out_o.status !== e.status || out_o.slot_index !== e.slot_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     e.status, e.slot_index, out_o.status, out_o.slot_index);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tile_lru_residency_tracker test failed");
      $finish;
    end
  end

  task automatic send_item(input tlrt_pkg::in_t it);
    start_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(residency_outcome(it));
    start_i <= 1'b0;
    // The block raises busy once it takes a transaction.
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_stride(input logic [10:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= '0; pwdata <= {21'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    stride = v;
  endtask

  function automatic tlrt_pkg::in_t make_item(input tlrt_pkg::mode_e m, input int c,
                                              input int r, input int k);
    tlrt_pkg::in_t it;
    it.mode = m; it.tile_col = c[9:0]; it.tile_row = r[9:0]; it.access_kind = k[1:0];
    return it;
  endfunction

  task automatic directed_corners();
    send_item(make_item(tlrt_pkg::MODE_QUERY, 0, 0, 0));
    send_item(make_item(tlrt_pkg::MODE_MARK, 0, 5, 2));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 0, 0, 0));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 0, 0, 1));
    send_item(make_item(tlrt_pkg::MODE_QUERY, 0, 0, 0));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 1, 3, 2));
    send_item(make_item(tlrt_pkg::MODE_QUERY, 1, 3, 0));
    send_item(make_item(tlrt_pkg::MODE_MARK, 1, 3, 3));
    send_item(make_item(tlrt_pkg::MODE_MARK, 1, 3, 1));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 1, 3, 0));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 1, 3, 0));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 1023, 1023, 3));
    send_item(make_item(tlrt_pkg::MODE_RSVD, 0, 0, 3));
    send_item(make_item(tlrt_pkg::MODE_ACCESS, 31, 31, 3));
    send_item(make_item(tlrt_pkg::MODE_QUERY, 31, 31, 3));
    drain();
  endtask

  // Walks more tiles than slots (80 against 64) so the oldest slot is reclaimed.
  task automatic eviction_sweep();
    for (int i = 0; i < 80; i++) send_item(make_item(tlrt_pkg::MODE_ACCESS, 0, i, i % 4));
    for (int i = 0; i < 20; i++) send_item(make_item(tlrt_pkg::MODE_QUERY, 0, i, 0));
    drain();
  endtask

  task automatic random_traffic(input int n, input int max_tile);
    int sent, burst;
    int col, row, t;
    tlrt_pkg::in_t it;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        t = $urandom_range(0, max_tile);
        col = t / int'(stride);
        row = t % int'(stride);
        if ($urandom_range(0, 9) == 0) begin
          col = $urandom_range(0, 1023); row = $urandom_range(0, 1023);
        end
        if (col > 1023) col = 1023;
        case ($urandom_range(0, 15))
          0: it = make_item(tlrt_pkg::MODE_RSVD, col, row, $urandom_range(0, 3));
          1, 2, 3: it = make_item(tlrt_pkg::MODE_MARK, col, row, $urandom_range(0, 3));
          4, 5, 6: it = make_item(tlrt_pkg::MODE_QUERY, col, row, $urandom_range(0, 3));
          default: it = make_item(tlrt_pkg::MODE_ACCESS, col, row, $urandom_range(0, 3));
        endcase
        send_item(it);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 10)) @(posedge clk_i);
      if ($urandom_range(0, 40) == 0) drain();
    end
    drain();
  endtask

  task automatic stride_settings();
    write_stride(11'd1);    random_traffic(300, 100);
    write_stride(11'd1024); random_traffic(300, 1023);
    write_stride(11'd7);    random_traffic(300, 90);
    write_stride(11'd32);   random_traffic(300, 1023);
  endtask

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_corners();
    eviction_sweep();
    stride_settings();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tile_lru_residency_tracker test passed");
    end else begin
      $display("tile_lru_residency_tracker test failed");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/tlrt_pkg.sv
hw/rtl/tlrt_ram.sv
hw/rtl/tlrt_cell.sv
hw/rtl/tile_lru_residency_tracker.sv
test/tile_lru_residency_tracker_test.sv
